>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off during reset.
`define RGBS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication; the consequent is checked in the cycle after the antecedent.
`define RGBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/rgbs_pkg.sv
package rgbs_pkg;

	localparam int unsigned MAX_LEDS = 1920;
	localparam int unsigned LEDS_PER_LATCH = 32;

	localparam int unsigned IDX_W = 11;
	localparam int unsigned CNT_W = 6;

	localparam logic       OP_PIXEL = 1'b0;
	localparam logic       OP_PRIME = 1'b1;

	localparam logic [1:0] DEPTH_332 = 2'd1;
	localparam logic [1:0] DEPTH_555 = 2'd2;
	localparam logic [1:0] DEPTH_GRB = 2'd3;

	localparam logic       REG_COLOR_DEPTH = 1'b0;
	localparam logic       REG_LED_COUNT   = 1'b1;

	localparam logic [7:0] COLOR_MARK = 8'h80;

	typedef struct packed {
		logic             has_pixel;
		logic [7:0]       g;
		logic [7:0]       r;
		logic [7:0]       b;
		logic [CNT_W-1:0] latch_n;
	} bundle_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] pos;
		logic [CNT_W-1:0] total;
	} emit_stat_t;

endpackage

>>> sv/rgb_strip_frame_serializer.sv
// channel  dir  handshake                  payload
// s_       in   s_tvalid / s_tready        s_tdata = pixel_value, s_tuser = opcode
// m_       out  m_tvalid / m_tready        m_tdata = out_byte, m_tlast = last
// cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A pixel gives 3 bytes plus ceil(count/32) latch zeros when it ends the frame;
// a prime gives only the latch zeros. One byte leaves per cycle from the output
// stage while m_tready is high.
// The input register takes the next item while the output stage still drains.
// Reset clears the valid flags and the frame counter; depth resets to 3, count to 32.
// cfg_ready is always high.
`include "assert_macros.svh"

module rgb_strip_frame_serializer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [23:0] pixel_value
	input  logic        s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] out_byte
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	logic [1:0]                      color_depth_q;
	logic [10:0]                     led_count_q;
	logic [rgbs_pkg::IDX_W-1:0]      pixel_index_q;
	logic [rgbs_pkg::IDX_W-1:0]      pixel_index_next;
	logic                            valid_s1;
	logic                            opcode_s1;
	logic [23:0]                     pixel_s1;
	logic                            s2_free;
	logic                            move;
	rgbs_pkg::bundle_t               bundle;
	rgbs_pkg::emit_stat_t            stat;

	assign cfg_ready = 1'b1;
	assign move      = valid_s1 && s2_free;
	assign s_tready  = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_depth_q <= rgbs_pkg::DEPTH_GRB;
			led_count_q   <= 11'd32;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rgbs_pkg::REG_COLOR_DEPTH: color_depth_q <= cfg_data[1:0];
				rgbs_pkg::REG_LED_COUNT:   led_count_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			pixel_index_q <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				pixel_index_q <= pixel_index_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1 <= s_tuser;
			pixel_s1  <= s_tdata;
		end
	end

	rgbs_decode u_decode (
		.opcode           (opcode_s1),
		.pixel_value      (pixel_s1),
		.color_depth      (color_depth_q),
		.led_count        (led_count_q),
		.pixel_index      (pixel_index_q),
		.bundle           (bundle),
		.pixel_index_next (pixel_index_next)
	);

	rgbs_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (move),
		.bundle   (bundle),
		.free     (s2_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.stat     (stat)
	);

	`RGBS_ASSERT(a_pos_in_range, stat.busy |-> (stat.pos < stat.total), "byte position past item end")
	`RGBS_ASSERT(a_index_bound, pixel_index_q < 11'(rgbs_pkg::MAX_LEDS), "frame counter out of range")
	`RGBS_ASSERT(a_byte_form, (m_tvalid && m_tdata != 8'd0) |-> m_tdata[7], "color byte without mark bit")
	`RGBS_ASSERT_NEXT(a_clear_on_prime, move && opcode_s1 == rgbs_pkg::OP_PRIME, pixel_index_q == '0, "prime did not clear frame counter")

endmodule

>>> sv/rgbs_decode.sv
module rgbs_decode (
	input  logic                        opcode,
	input  logic [23:0]                 pixel_value,
	input  logic [1:0]                  color_depth,
	input  logic [10:0]                 led_count,
	input  logic [rgbs_pkg::IDX_W-1:0]  pixel_index,
	output rgbs_pkg::bundle_t           bundle,
	output logic [rgbs_pkg::IDX_W-1:0]  pixel_index_next
);

	logic [10:0]               eff_count;
	logic [11:0]               latch_sum;
	logic [11:0]               index_inc;
	logic [6:0]                latch_full;
	logic [7:0]                g, r, b;
	logic                      frame_done;

	always_comb begin
		eff_count  = (led_count > 11'(rgbs_pkg::MAX_LEDS)) ? 11'(rgbs_pkg::MAX_LEDS) : led_count;
		latch_sum  = {1'b0, eff_count} + 12'(rgbs_pkg::LEDS_PER_LATCH - 1);
		latch_full = 7'(latch_sum / 12'(rgbs_pkg::LEDS_PER_LATCH));
		index_inc  = {1'b0, pixel_index} + 12'd1;
		frame_done = (index_inc >= {1'b0, eff_count});
	end

	always_comb begin
		g = 8'd0;
		r = 8'd0;
		b = 8'd0;
		unique case (color_depth)
			rgbs_pkg::DEPTH_332: begin
				r = {1'b0, pixel_value[7:5], 4'd0};
				g = {1'b0, pixel_value[4:2], 4'd0};
				b = {1'b0, pixel_value[1:0], 5'd0};
			end
			rgbs_pkg::DEPTH_555: begin
				r = {1'b0, pixel_value[14:10], 2'd0};
				g = {1'b0, pixel_value[9:5], 2'd0};
				b = {1'b0, pixel_value[4:0], 2'd0};
			end
			rgbs_pkg::DEPTH_GRB: begin
				g = pixel_value[23:16];
				r = pixel_value[15:8];
				b = pixel_value[7:0];
			end
			default: begin
				g = 8'd0;
				r = 8'd0;
				b = 8'd0;
			end
		endcase
	end

	always_comb begin
		bundle.has_pixel = (opcode == rgbs_pkg::OP_PIXEL);
		bundle.g         = g | rgbs_pkg::COLOR_MARK;
		bundle.r         = r | rgbs_pkg::COLOR_MARK;
		bundle.b         = b | rgbs_pkg::COLOR_MARK;
		if (opcode == rgbs_pkg::OP_PRIME || frame_done) begin
			bundle.latch_n   = latch_full[rgbs_pkg::CNT_W-1:0];
			pixel_index_next = '0;
		end else begin
			bundle.latch_n   = '0;
			pixel_index_next = index_inc[rgbs_pkg::IDX_W-1:0];
		end
	end

endmodule

>>> sv/rgbs_emit.sv
module rgbs_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  rgbs_pkg::bundle_t     bundle,
	output logic                  free,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata, // out_byte
	output logic                  m_tlast,
	output rgbs_pkg::emit_stat_t  stat
);

	localparam int unsigned CW = rgbs_pkg::CNT_W;

	rgbs_pkg::bundle_t bundle_s2;
	logic              valid_s2;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     total_s2;
	logic [CW-1:0]     load_total;
	logic              fire;

	assign load_total = bundle.has_pixel ? bundle.latch_n + CW'(3) : bundle.latch_n;
	assign m_tvalid   = valid_s2;
	assign m_tlast    = (pos_q == total_s2 - CW'(1));
	assign fire       = valid_s2 && m_tready;
	assign free       = !valid_s2 || (fire && m_tlast);

	always_comb begin
		m_tdata = 8'd0;
		if (bundle_s2.has_pixel) begin
			priority if (pos_q == CW'(0)) begin
				m_tdata = bundle_s2.g;
			end else if (pos_q == CW'(1)) begin
				m_tdata = bundle_s2.r;
			end else if (pos_q == CW'(2)) begin
				m_tdata = bundle_s2.b;
			end else begin
				m_tdata = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_q    <= '0;
		end else if (load) begin
			valid_s2 <= (load_total != '0);
			pos_q    <= '0;
		end else if (fire) begin
			if (m_tlast) begin
				valid_s2 <= 1'b0;
				pos_q    <= '0;
			end else begin
				pos_q <= pos_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s2 <= bundle;
			total_s2  <= load_total;
		end
	end

	assign stat.busy  = valid_s2;
	assign stat.pos   = pos_q;
	assign stat.total = total_s2;

endmodule
